// File: rtl/cfp_pkg.sv
// Shared constants and types for the command frame parser.
package cfp_pkg;

    localparam int PAYLOAD_DEPTH = 33;
    localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
    localparam int BYTE_W        = 8;
    localparam int BYTE_INDEX_W  = 6;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 1;

    localparam logic [REG_W-1:0] REG_START_BYTE = 1'd0;
    localparam logic [REG_W-1:0] REG_STOP_BYTE  = 1'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] STOP_BYTE_RESET  = 8'hAF;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] stop_byte;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

endpackage

// File: rtl/cfp_ram.sv
// Single-port-write, registered-read memory for the payload bytes.
module cfp_ram #(
    parameter int DEPTH = 33,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/cfp_cfg_regs.sv
// APB register file holding the start and stop byte values.
module cfp_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfp_pkg::PDATA_W-1:0]  pwdata,
    output logic [cfp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output cfp_pkg::cfg_t                cfg
);

    logic [cfp_pkg::BYTE_W-1:0] start_byte_reg;
    logic [cfp_pkg::BYTE_W-1:0] stop_byte_reg;
    logic [cfp_pkg::REG_W-1:0]  reg_sel;
    logic                       wr_strobe;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[cfp_pkg::PADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= cfp_pkg::START_BYTE_RESET;
            stop_byte_reg  <= cfp_pkg::STOP_BYTE_RESET;
        end
        else if (wr_strobe)
        begin
            unique case (reg_sel)
                cfp_pkg::REG_START_BYTE: start_byte_reg <= pwdata[cfp_pkg::BYTE_W-1:0];
                cfp_pkg::REG_STOP_BYTE:  stop_byte_reg  <= pwdata[cfp_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            cfp_pkg::REG_START_BYTE:
                prdata = {{(cfp_pkg::PDATA_W-cfp_pkg::BYTE_W){1'b0}}, start_byte_reg};
            cfp_pkg::REG_STOP_BYTE:
                prdata = {{(cfp_pkg::PDATA_W-cfp_pkg::BYTE_W){1'b0}}, stop_byte_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.start_byte = start_byte_reg;
    assign cfg.stop_byte  = stop_byte_reg;

endmodule

// File: rtl/cfp_frame_fsm.sv
// Frame parse state machine, checksum, and result sequencer over the payload memory.
module cfp_frame_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfp_pkg::cfg_t                   cfg,
    input  logic                            rx_valid,
    output logic                            rx_stall,
    input  logic [cfp_pkg::BYTE_W-1:0]      rx_byte,
    output cfp_pkg::ram_wr_t                ram_wr,
    output logic [cfp_pkg::IDX_W-1:0]       ram_rd_addr,
    input  logic [cfp_pkg::BYTE_W-1:0]      ram_rd_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [cfp_pkg::BYTE_W-1:0]      frame_type,
    output logic [cfp_pkg::BYTE_W-1:0]      frame_number,
    output logic [cfp_pkg::BYTE_W-1:0]      frame_count,
    output logic                            has_data,
    output logic [cfp_pkg::BYTE_INDEX_W-1:0] byte_index,
    output logic [cfp_pkg::BYTE_W-1:0]      payload_byte,
    output logic                            last
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_NUMBER = 3'd2;
    localparam logic [2:0] PH_COUNT  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;
    localparam logic [2:0] PH_STOP   = 3'd6;
    localparam logic [2:0] PH_EMIT   = 3'd7;

    localparam int BW = cfp_pkg::BYTE_W;
    localparam int CW = cfp_pkg::CNT_W;
    localparam int IW = cfp_pkg::IDX_W;

    logic [2:0]    phase_reg,    phase_next;
    logic [BW-1:0] type_reg,     type_next;
    logic [BW-1:0] number_reg,   number_next;
    logic [BW-1:0] count_reg,    count_next;
    logic [CW-1:0] stored_reg,   stored_next;
    logic [BW-1:0] checksum_reg, checksum_next;
    logic [BW-1:0] sum_reg,      sum_next;
    logic [IW-1:0] idx_reg,      idx_next;

    logic          res_valid_reg, res_valid_next;
    logic          load;
    logic          ld_has, ld_last;
    logic [IW-1:0] ld_index;
    logic [BW-1:0] ld_payload;

    logic [BW-1:0] frame_type_reg, frame_number_reg, frame_count_reg, payload_reg;
    logic          has_data_reg, last_reg;
    logic [cfp_pkg::BYTE_INDEX_W-1:0] byte_index_reg;

    logic          accept;
    logic          out_free;
    logic [CW-1:0] stored_inc;
    logic [CW-1:0] idx_inc;

    assign rx_stall   = (phase_reg == PH_EMIT);
    assign accept     = rx_valid && !rx_stall;
    assign out_free   = !res_valid_reg || !res_stall;
    assign stored_inc = stored_reg + CW'(1);
    assign idx_inc    = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        number_next   = number_reg;
        count_next    = count_reg;
        stored_next   = stored_reg;
        checksum_next = checksum_reg;
        sum_next      = sum_reg;
        idx_next      = idx_reg;
        ram_wr.en     = 1'b0;
        ram_wr.addr   = stored_reg[IW-1:0];
        ram_wr.data   = rx_byte;
        load          = 1'b0;
        ld_has        = 1'b0;
        ld_last       = 1'b0;
        ld_index      = '0;
        ld_payload    = '0;

        unique case (phase_reg)
            PH_TYPE:
            begin
                if (accept)
                begin
                    type_next  = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = PH_NUMBER;
                end
            end
            PH_NUMBER:
            begin
                if (accept)
                begin
                    number_next = rx_byte;
                    sum_next    = sum_reg + rx_byte;
                    phase_next  = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (accept)
                begin
                    count_next  = rx_byte;
                    sum_next    = sum_reg + rx_byte;
                    stored_next = '0;
                    phase_next  = (rx_byte == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (accept)
                begin
                    ram_wr.en   = 1'b1;
                    stored_next = stored_inc;
                    sum_next    = sum_reg + rx_byte;
                    // leave at the declared count or when the store is full
                    if ((BW'(stored_inc) >= count_reg) ||
                        (stored_inc >= CW'(cfp_pkg::PAYLOAD_DEPTH)))
                    begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK:
            begin
                if (accept)
                begin
                    checksum_next = rx_byte;
                    phase_next    = PH_STOP;
                end
            end
            PH_STOP:
            begin
                if (accept && (rx_byte == cfg.stop_byte))
                begin
                    idx_next   = '0;
                    phase_next = (sum_reg == checksum_reg) ? PH_EMIT : PH_START;
                end
            end
            PH_EMIT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (count_reg == '0)
                    begin
                        ld_last    = 1'b1;
                        phase_next = PH_START;
                    end
                    else
                    begin
                        ld_has     = 1'b1;
                        ld_index   = idx_reg;
                        ld_payload = ram_rd_data;
                        ld_last    = (idx_inc == stored_reg);
                        if (idx_inc == stored_reg)
                        begin
                            idx_next   = '0;
                            phase_next = PH_START;
                        end
                        else
                        begin
                            idx_next = idx_inc[IW-1:0];
                        end
                    end
                end
            end
            default:
            begin
                if (accept && (rx_byte == cfg.start_byte))
                begin
                    phase_next = PH_TYPE;
                end
            end
        endcase
    end

    // Read ahead so the next payload byte is ready when the output frees up.
    assign ram_rd_addr = idx_next;

    always_comb
    begin
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            type_reg      <= '0;
            number_reg    <= '0;
            count_reg     <= '0;
            stored_reg    <= '0;
            checksum_reg  <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            number_reg    <= number_next;
            count_reg     <= count_next;
            stored_reg    <= stored_next;
            checksum_reg  <= checksum_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_type_reg   <= type_reg;
            frame_number_reg <= number_reg;
            frame_count_reg  <= count_reg;
            has_data_reg     <= ld_has;
            byte_index_reg   <= cfp_pkg::BYTE_INDEX_W'(ld_index);
            payload_reg      <= ld_payload;
            last_reg         <= ld_last;
        end
    end

    assign res_valid    = res_valid_reg;
    assign frame_type   = frame_type_reg;
    assign frame_number = frame_number_reg;
    assign frame_count  = frame_count_reg;
    assign has_data     = has_data_reg;
    assign byte_index   = byte_index_reg;
    assign payload_byte = payload_reg;
    assign last         = last_reg;

endmodule

// File: rtl/command_frame_parser.sv
// Top level of the command frame parser: byte-in, per-payload-byte results out (one beat for an empty frame).
//
//   channel  | direction | handshake             | beat contents
//   rx       | in        | rx_valid / rx_stall   | rx_byte
//   res      | out       | res_valid / res_stall | frame_type .. last
//   apb      | in        | psel / penable        | start_byte, stop_byte registers
//
// One received byte is taken per cycle while a frame is being parsed.
// A stop byte that closes a good frame is followed by 1 to 33 result beats,
// one per cycle from the payload memory's registered read port; rx stalls meanwhile.
// A stall on res holds the result register and pauses the read sequencer.
// Reset returns the parser to waiting for the start byte; no memory clearing pass.
module command_frame_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfp_pkg::PADDR_W-1:0]      paddr,
    input  logic [cfp_pkg::PDATA_W-1:0]      pwdata,
    output logic [cfp_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             rx_valid,
    output logic                             rx_stall,
    input  logic [cfp_pkg::BYTE_W-1:0]       rx_byte,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [cfp_pkg::BYTE_W-1:0]       frame_type,
    output logic [cfp_pkg::BYTE_W-1:0]       frame_number,
    output logic [cfp_pkg::BYTE_W-1:0]       frame_count,
    output logic                             has_data,
    output logic [cfp_pkg::BYTE_INDEX_W-1:0] byte_index,
    output logic [cfp_pkg::BYTE_W-1:0]       payload_byte,
    output logic                             last
);

    cfp_pkg::cfg_t                 cfg;
    cfp_pkg::ram_wr_t              ram_wr;
    logic [cfp_pkg::IDX_W-1:0]     ram_rd_addr;
    logic [cfp_pkg::BYTE_W-1:0]    ram_rd_data;

    cfp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfp_ram #(
        .DEPTH (cfp_pkg::PAYLOAD_DEPTH),
        .WIDTH (cfp_pkg::BYTE_W),
        .AW    (cfp_pkg::IDX_W)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    cfp_frame_fsm u_frame_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .ram_wr       (ram_wr),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .frame_type   (frame_type),
        .frame_number (frame_number),
        .frame_count  (frame_count),
        .has_data     (has_data),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (last)
    );

endmodule

// File: rtl/cfp_checker.sv
// Port-level checks on the command frame parser, bound to the top level.
module cfp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             rx_stall,
    input logic                             res_valid,
    input logic                             res_stall,
    input logic                             has_data,
    input logic [cfp_pkg::BYTE_INDEX_W-1:0] byte_index,
    input logic [cfp_pkg::BYTE_W-1:0]       payload_byte,
    input logic                             last
);

    // a stalled result beat stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(byte_index) && $stable(last))
        else $error("result beat dropped or changed under stall");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !has_data |-> last && (byte_index == '0) && (payload_byte == '0))
        else $error("empty-frame result malformed");

    // payload run streams back to back with rising index
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && has_data && !last |=>
            res_valid && has_data &&
            (byte_index == $past(byte_index) + cfp_pkg::BYTE_INDEX_W'(1)))
        else $error("payload run broken");

    a_rx_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_data && !last |-> rx_stall)
        else $error("input taken during a payload run");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_stall     (rx_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .has_data     (has_data),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .last         (last)
);
